@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define LTACC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Overlapping implication built on the clocked form.
`define LTACC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  `LTACC_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

@@ rtl/ltacc_pkg.sv @@
// ----------------------------------------------------------------------------
// Looping time accumulator package
// Widths, codes, register map and shared types of the playback clock.
// ----------------------------------------------------------------------------
package ltacc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int STAMP_BITS = 16;

  localparam int TIME_W   = 32;
  localparam int STEP_W   = 24;
  localparam int VEL_W    = 24;
  localparam int FSTAMP_W = 16;
  localparam int STAMP_W  = (STAMP_BITS < FSTAMP_W) ? STAMP_BITS : FSTAMP_W;

  // Product of the unsigned step and the signed velocity, and the floored shift.
  localparam int PROD_W    = STEP_W + VEL_W + 1;
  localparam int DELTA_W   = PROD_W - FRAC_BITS;
  localparam int NEXT_W    = ((TIME_W + 1 > DELTA_W) ? TIME_W + 1 : DELTA_W) + 1;
  localparam int NUM_W     = NEXT_W - 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int MUL_CNT_W = $clog2(STEP_W + 1);

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int REG_IW = APB_AW - 2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  typedef enum logic [REG_IW-1:0] {
    REG_DURATION   = 3'd0,
    REG_VELOCITY   = 3'd1,
    REG_LOOPED     = 3'd2,
    REG_NORMALIZED = 3'd3,
    REG_STOP_BEH   = 3'd4
  } reg_e;

  localparam logic [1:0] STOP_RESET  = 2'd1;
  localparam logic [1:0] STOP_FINISH = 2'd2;

  localparam logic [VEL_W-1:0]  VEL_ONE  = VEL_W'(1) << FRAC_BITS;
  localparam logic [TIME_W-1:0] EVAL_ONE = TIME_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [TIME_W-1:0]       duration;
    logic signed [VEL_W-1:0] velocity;
    logic                    looped;
    logic                    normalized;
    logic [1:0]              stop_beh;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

endpackage

@@ rtl/ltacc_in_if.sv @@
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel carrying one command beat: mode, step and frame stamp.
// ----------------------------------------------------------------------------
interface ltacc_in_if import ltacc_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [STEP_W-1:0]   step;
  logic [FSTAMP_W-1:0] frame_stamp;

  modport source (output valid, output mode, output step, output frame_stamp, input ready);
  modport sink   (input valid, input mode, input step, input frame_stamp, output ready);

endinterface

@@ rtl/ltacc_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one result beat: evaluated time, time, run flag.
// ----------------------------------------------------------------------------
interface ltacc_out_if import ltacc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] eval_value;
  logic [TIME_W-1:0] time_value;
  logic              running;

  modport source (output valid, output eval_value, output time_value, output running,
                  input ready);
  modport sink   (input valid, input eval_value, input time_value, input running,
                  output ready);

endinterface

@@ rtl/looping_time_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// Looping time accumulator
// Animation playback clock in unsigned Q16.16 time with wrap or clamp at the
// clip ends and an optional normalized Q16.16 output from 0 to 1.0.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_i     sink       mode, step, frame_stamp
//  out_o    source     eval_value, time_value, running
//  APB      slave      duration, velocity, looped, normalized, stop_behavior
//
// Start, stop, reset-time commands and ignored ticks go from idle straight to push.
// A tick that moves the clock runs the serial multiplier, then the divider for
// the wrap modulo when looping and the new time leaves the clip, then the same
// divider for the normalized fraction when that output is on.
// One command is in flight at a time; the result register holds a beat under
// stall while the next command is taken, and a finished result waits for it.
// Reset is asynchronous and needs no clearing pass.
module looping_time_accumulator_unit import ltacc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ltacc_in_if.sink          in_i,
  ltacc_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_MOD,
    S_EVAL,
    S_DIV,
    S_PUSH
  } state_e;

  state_e state_q, state_d;

  logic [TIME_W-1:0]        play_q, play_d;
  logic [TIME_W-1:0]        eval_q, eval_d;
  logic [STAMP_W-1:0]       prev_q, prev_d;
  logic                     seen_q, seen_d;
  logic                     run_q, run_d;
  logic signed [NEXT_W-1:0] next_q, next_d;
  logic                     neg_q, neg_d;
  logic                     out_valid_q, out_valid_d;
  logic [TIME_W-1:0]        out_eval_q, out_eval_d;
  logic [TIME_W-1:0]        out_time_q, out_time_d;
  logic                     out_run_q, out_run_d;

  cfg_t                     cfg;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [PROD_W-1:0] prod;
  logic signed [DELTA_W-1:0] delta;
  logic signed [NEXT_W-1:0] next_sum;
  logic signed [NEXT_W-1:0] next_neg;
  logic                     next_below;
  logic                     next_above;
  logic                     wrap_en;
  div_req_t                 div_req;
  logic [TIME_W-1:0]        div_rem_init;
  logic [NUM_W-1:0]         div_num;
  logic [TIME_W-1:0]        div_rem;
  logic [NUM_W-1:0]         div_quo;
  logic                     div_done;
  logic [STAMP_W-1:0]       stamp;
  mode_e                    mode;

  ltacc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ltacc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .step_i  (in_i.step),
    .vel_i   (cfg.velocity),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  ltacc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .dvs_i      (cfg.duration),
    .rem_o      (div_rem),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  assign stamp = in_i.frame_stamp[STAMP_W-1:0];
  assign mode  = mode_e'(in_i.mode);

  // An arithmetic shift of the product floors toward minus infinity.
  assign delta    = prod[PROD_W-1:FRAC_BITS];
  assign next_sum = NEXT_W'({1'b0, play_q}) + NEXT_W'(delta);
  assign next_neg = -next_q;

  assign next_below = next_q[NEXT_W-1];
  assign next_above = !next_q[NEXT_W-1] &&
                      (next_q[NEXT_W-2:0] > (NEXT_W-1)'(cfg.duration));
  assign wrap_en    = cfg.looped && (cfg.duration != '0);

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.eval_value = out_eval_q;
  assign out_o.time_value = out_time_q;
  assign out_o.running    = out_run_q;

  always_comb begin
    state_d      = state_q;
    play_d       = play_q;
    eval_d       = eval_q;
    prev_d       = prev_q;
    seen_d       = seen_q;
    run_d        = run_q;
    next_d       = next_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q;
    out_eval_d   = out_eval_q;
    out_time_d   = out_time_q;
    out_run_d    = out_run_q;
    mul_start    = 1'b0;
    div_req      = '0;
    div_rem_init = '0;
    div_num      = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_PUSH;
          unique case (mode)
            MODE_TICK: begin
              if (run_q && !(seen_q && (prev_q == stamp)) && (cfg.velocity != '0)) begin
                prev_d    = stamp;
                seen_d    = 1'b1;
                mul_start = 1'b1;
                state_d   = S_MUL;
              end
            end
            MODE_START: run_d = 1'b1;
            MODE_STOP: begin
              if (run_q) begin
                run_d = 1'b0;
                if (cfg.stop_beh == STOP_RESET) begin
                  play_d = '0;
                  eval_d = '0;
                end else if (cfg.stop_beh == STOP_FINISH) begin
                  play_d = cfg.duration;
                  eval_d = cfg.normalized ? EVAL_ONE : cfg.duration;
                end
              end
            end
            MODE_RESET: begin
              play_d = '0;
              eval_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          next_d  = next_sum;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_EVAL;
        if (next_below || next_above) begin
          if (wrap_en) begin
            neg_d         = next_below;
            div_req.start = 1'b1;
            div_req.steps = DIV_CNT_W'(NUM_W);
            div_num       = next_below ? next_neg[NUM_W-1:0] : next_q[NUM_W-1:0];
            state_d       = S_MOD;
          end else begin
            play_d = next_below ? '0 : cfg.duration;
          end
        end else begin
          play_d = next_q[TIME_W-1:0];
        end
      end
      S_MOD: begin
        if (div_done) begin
          play_d  = neg_q ? (cfg.duration - div_rem) : div_rem;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_PUSH;
        if (cfg.normalized) begin
          if (cfg.duration != '0) begin
            // The time is at most the duration, so the quotient fits in one
            // bit above the fraction and the upper dividend bits seed the
            // remainder directly.
            div_req.start = 1'b1;
            div_req.steps = DIV_CNT_W'(FRAC_BITS + 1);
            div_rem_init  = {1'b0, play_q[TIME_W-1:1]};
            div_num       = {play_q[0], {(NUM_W-1){1'b0}}};
            state_d       = S_DIV;
          end else begin
            eval_d = '0;
          end
        end else begin
          eval_d = play_q;
        end
      end
      S_DIV: begin
        if (div_done) begin
          eval_d  = div_quo[TIME_W-1:0];
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_eval_d  = eval_q;
          out_time_d  = play_q;
          out_run_d   = run_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      play_q      <= '0;
      eval_q      <= '0;
      prev_q      <= '0;
      seen_q      <= 1'b0;
      run_q       <= 1'b0;
      next_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_eval_q  <= '0;
      out_time_q  <= '0;
      out_run_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      play_q      <= play_d;
      eval_q      <= eval_d;
      prev_q      <= prev_d;
      seen_q      <= seen_d;
      run_q       <= run_d;
      next_q      <= next_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_eval_q  <= out_eval_d;
      out_time_q  <= out_time_d;
      out_run_q   <= out_run_d;
    end
  end

endmodule

@@ rtl/ltacc_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for duration, velocity, loop, normalize and stop rule.
// ----------------------------------------------------------------------------
module ltacc_cfg import ltacc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  reg_e reg_idx;
  logic wr_en;

  assign reg_idx = reg_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration   <= '0;
      cfg_q.velocity   <= VEL_ONE;
      cfg_q.looped     <= 1'b1;
      cfg_q.normalized <= 1'b0;
      cfg_q.stop_beh   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DURATION:   cfg_q.duration   <= pwdata[TIME_W-1:0];
        REG_VELOCITY:   cfg_q.velocity   <= pwdata[VEL_W-1:0];
        REG_LOOPED:     cfg_q.looped     <= pwdata[0];
        REG_NORMALIZED: cfg_q.normalized <= pwdata[0];
        REG_STOP_BEH:   cfg_q.stop_beh   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DURATION:   prdata = APB_DW'(cfg_q.duration);
      REG_VELOCITY:   prdata = APB_DW'(unsigned'(cfg_q.velocity));
      REG_LOOPED:     prdata = APB_DW'(cfg_q.looped);
      REG_NORMALIZED: prdata = APB_DW'(cfg_q.normalized);
      REG_STOP_BEH:   prdata = APB_DW'(cfg_q.stop_beh);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/ltacc_mul.sv @@
// ----------------------------------------------------------------------------
// Serial step multiplier
// Shift-add multiply of the unsigned step by the signed velocity, one step bit
// per cycle.
// ----------------------------------------------------------------------------
module ltacc_mul import ltacc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [STEP_W-1:0]        step_i,
  input  logic signed [VEL_W-1:0]  vel_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic                     done_o
);

  logic signed [VEL_W:0]  hi_q, hi_d;
  logic [STEP_W-1:0]      lo_q, lo_d;
  logic [MUL_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic signed [VEL_W:0]  addend;
  logic signed [VEL_W:0]  sum;

  // The running partial product never exceeds the velocity in magnitude, so
  // one guard bit over the velocity holds the sum.
  assign addend = lo_q[0] ? {vel_i[VEL_W-1], vel_i} : '0;
  assign sum    = hi_q + addend;

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = step_i;
      cnt_d  = MUL_CNT_W'(STEP_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = {sum[VEL_W], sum[VEL_W:1]};
      lo_d  = {sum[0], lo_q[STEP_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

@@ rtl/ltacc_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division by the duration, one numerator bit per cycle; serves both
// the wrap modulo and the normalized fraction.
// ----------------------------------------------------------------------------
module ltacc_div import ltacc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  input  logic [TIME_W-1:0] rem_init_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [TIME_W-1:0] dvs_i,
  output logic [TIME_W-1:0] rem_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic              done_o
);

  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 fits;

  // The numerator shifts out at the top while quotient bits fill in below.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_i});
  assign diff  = trial - {1'b0, dvs_i};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = rem_init_i;
      num_d  = num_i;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign rem_o  = rem_q;
  assign quo_o  = num_q;
  assign done_o = done_q;

endmodule

@@ rtl/ltacc_checker.sv @@
// ----------------------------------------------------------------------------
// Looping time accumulator checker
// Port-level assertions on command sequencing and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltacc_checker import ltacc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_mode_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [TIME_W-1:0] out_eval_value_i,
  input logic [TIME_W-1:0] out_time_value_i,
  input logic              out_running_i
);

  logic in_beat;
  logic cmd_fast;

  assign in_beat  = in_valid_i && in_ready_i;
  assign cmd_fast = in_beat && !out_valid_i;

  // A stalled result beat keeps its contents.
  `LTACC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_eval_value_i) && $stable(out_time_value_i) && $stable(out_running_i)))

  // Only one command is in flight at a time.
  `LTACC_ASSERT(a_one_in_flight, clk_i, rst_ni, in_beat |=> !in_ready_i)

  // A start command into an empty result register shows a running clock once
  // the push state has registered the result.
  `LTACC_ASSERT_IMP(a_start_result, clk_i, rst_ni, cmd_fast && (in_mode_i == MODE_START), ##2 (out_valid_i && out_running_i))

  // A reset-time command clears both the time and the evaluated value.
  `LTACC_ASSERT_IMP(a_reset_result, clk_i, rst_ni, cmd_fast && (in_mode_i == MODE_RESET), ##2 (out_valid_i && (out_time_value_i == '0) && (out_eval_value_i == '0)))

endmodule

bind looping_time_accumulator_unit ltacc_checker u_ltacc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_mode_i        (in_i.mode),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_eval_value_i (out_o.eval_value),
  .out_time_value_i (out_o.time_value),
  .out_running_i    (out_o.running)
);
